@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

@@ hw/rtl/skar_pkg.sv @@
// ----------------------------------------------------------------------------
// skar_pkg
// Shared widths, reset values and codes of the key auto-release block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skar_pkg;

  // field widths
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned IDX_OUT_W  = 3;
  localparam int unsigned IN_DATA_W  = 56;  // rx_char + now_us, whole bytes
  localparam int unsigned OUT_DATA_W = 8;   // key_index padded to a byte

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS     = 2'd1;

  // register reset values
  localparam logic [TIME_W-1:0]     DELAY_RESET = 48'd350000;
  localparam logic [CFG_DATA_W-1:0] CHARS_RESET = 64'h6D6E_656B_6173_6477;

  // request kind carried in tuser
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_TIME = 1'b1;

  // parameter defaults
  localparam int unsigned NUM_KEYS_DEF  = 8;
  localparam int unsigned TIME_BITS_DEF = 48;

endpackage

`default_nettype wire

@@ hw/rtl/skar_unit.sv @@
// ----------------------------------------------------------------------------
// skar_unit
// Shared per-key test: character match or release-due time compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skar_unit (
  input  logic                        func_i,
  input  logic [skar_pkg::CHAR_W-1:0] rx_char_i,
  input  logic [skar_pkg::CHAR_W-1:0] key_char_i,
  input  logic [skar_pkg::TIME_W-1:0] now_i,
  input  logic [skar_pkg::TIME_W-1:0] stamp_i,
  input  logic [skar_pkg::TIME_W-1:0] delay_i,
  output logic                        hit_o
);

  logic [skar_pkg::TIME_W:0] due_time;
  logic                      time_hit;

  // now > t + delay covers both now > t and now - t > delay
  assign due_time = {1'b0, stamp_i} + {1'b0, delay_i};
  assign time_hit = (stamp_i != '0) && ({1'b0, now_i} > due_time);

  assign hit_o = (func_i == skar_pkg::FUNC_TIME) ? time_hit : (rx_char_i == key_char_i);

endmodule

`default_nettype wire

@@ hw/rtl/serial_key_press_auto_release.sv @@
// ----------------------------------------------------------------------------
// serial_key_press_auto_release
// Maps received characters to key presses and releases keys after a delay.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake             Contents
// s_axis   in   tvalid/tready         tdata: rx_char[7:0], now_us[55:8]; tuser: func
// m_axis   out  tvalid/tready         tdata: key_index[2:0]; tuser: key_down; tlast
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data (always ready)
//
// A request is accepted in ST_IDLE, scans the keys one by one through the shared
// compare unit (up to NUM_KEYS) and ends in ST_FLUSH; only then is the next taken.
// A character request stops scanning at its first matching key.
// Output backpressure stalls the scan only when an event must be pushed.
// Reset clears all press times, restores register defaults, and empties the
// output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module serial_key_press_auto_release #(
  parameter int unsigned NUM_KEYS  = skar_pkg::NUM_KEYS_DEF,
  parameter int unsigned TIME_BITS = skar_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input requests
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [skar_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,   // rx_char, now_us
  input  logic                            s_axis_tuser_i,   // func
  // key events
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [skar_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,   // key_index, zero pad
  output logic                            m_axis_tuser_o,   // key_down
  output logic                            m_axis_tlast_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [skar_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [skar_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned STORE_W   = (TIME_BITS < skar_pkg::TIME_W) ? TIME_BITS
                                                                     : skar_pkg::TIME_W;
  localparam int unsigned KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KEY_IDX_W-1:0] LAST_IDX = KEY_IDX_W'(NUM_KEYS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e                           state_q;
  logic [KEY_IDX_W-1:0]             idx_q;
  logic                             func_q;
  logic [skar_pkg::CHAR_W-1:0]      char_q;
  logic [STORE_W-1:0]               now_q;
  logic [STORE_W-1:0]               press_q [NUM_KEYS];
  logic [skar_pkg::TIME_W-1:0]      delay_q;
  logic [skar_pkg::CFG_DATA_W-1:0]  key_chars_q;
  logic                             pend_v_q;
  logic [skar_pkg::IDX_OUT_W-1:0]   pend_idx_q;
  logic                             pend_down_q;
  logic                             out_v_q;
  logic [skar_pkg::IDX_OUT_W-1:0]   out_idx_q;
  logic                             out_down_q;
  logic                             out_last_q;

  logic [skar_pkg::TIME_W-1:0]      now_ext;
  logic [skar_pkg::TIME_W-1:0]      press_ext;
  logic [skar_pkg::CHAR_W-1:0]      key_char;
  logic                             unit_hit;
  logic                             can_push;
  logic                             scan_push;
  logic                             is_last;
  logic                             out_load;

  // operands for the shared unit
  always_comb begin
    now_ext = '0;
    now_ext[STORE_W-1:0] = now_q;
    press_ext = '0;
    press_ext[STORE_W-1:0] = press_q[idx_q];
  end

  assign key_char = key_chars_q[skar_pkg::CHAR_W*idx_q +: skar_pkg::CHAR_W];

  skar_unit u_unit (
    .func_i       (func_q),
    .rx_char_i    (char_q),
    .key_char_i   (key_char),
    .now_i        (now_ext),
    .stamp_i      (press_ext),
    .delay_i      (delay_q),
    .hit_o        (unit_hit)
  );

  // handshake helpers
  assign can_push  = !out_v_q || m_axis_tready_i;
  assign is_last   = (idx_q == LAST_IDX);
  assign scan_push = (state_q == ST_SCAN) && unit_hit && pend_v_q;

  // output register takes the pending event this cycle
  assign out_load  = pend_v_q && can_push &&
                     (((state_q == ST_SCAN) && unit_hit) || (state_q == ST_FLUSH));

  // sequencer, key store, config registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
      delay_q     <= skar_pkg::DELAY_RESET;
      key_chars_q <= skar_pkg::CHARS_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        press_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          skar_pkg::REG_RELEASE_DELAY: delay_q <= cfg_data_i[skar_pkg::TIME_W-1:0];
          skar_pkg::REG_KEY_CHARS:     key_chars_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_v_q && m_axis_tready_i && !out_load) begin
        out_v_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            func_q  <= s_axis_tuser_i;
            char_q  <= s_axis_tdata_i[skar_pkg::CHAR_W-1:0];
            now_q   <= s_axis_tdata_i[skar_pkg::CHAR_W +: STORE_W];
            idx_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (unit_hit) begin
            if (!pend_v_q || can_push) begin
              press_q[idx_q] <= (func_q == skar_pkg::FUNC_CHAR) ? now_q : '0;
              if (pend_v_q) begin
                out_v_q    <= 1'b1;
                out_idx_q  <= pend_idx_q;
                out_down_q <= pend_down_q;
                out_last_q <= 1'b0;
              end
              pend_v_q    <= 1'b1;
              pend_idx_q  <= skar_pkg::IDX_OUT_W'(idx_q);
              pend_down_q <= (func_q == skar_pkg::FUNC_CHAR);
              if ((func_q == skar_pkg::FUNC_CHAR) || is_last) begin
                state_q <= ST_FLUSH;
              end else begin
                idx_q <= idx_q + 1'b1;
              end
            end
          end else if (is_last) begin
            state_q <= ST_FLUSH;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (can_push) begin
            out_v_q    <= 1'b1;
            out_idx_q  <= pend_idx_q;
            out_down_q <= pend_down_q;
            out_last_q <= 1'b1;
            pend_v_q   <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ports
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(skar_pkg::OUT_DATA_W - skar_pkg::IDX_OUT_W){1'b0}}, out_idx_q};
  assign m_axis_tuser_o  = out_down_q;
  assign m_axis_tlast_o  = out_last_q;
  assign cfg_ready_o     = 1'b1;

  // checks
  `ASSERT_NEVER(a_idle_no_pending, clk_i, rst_ni, s_axis_tready_o && pend_v_q)
  `ASSERT_NEVER(a_char_single_event, clk_i, rst_ni,
                (state_q == ST_SCAN) && (func_q == skar_pkg::FUNC_CHAR) && pend_v_q)
  `ASSERT_PROP(a_stall_holds_scan, clk_i, rst_ni,
               (scan_push && !can_push) |=> ((state_q == ST_SCAN) && $stable(idx_q)))
  `ASSERT_PROP(a_empty_flush_to_idle, clk_i, rst_ni,
               ((state_q == ST_FLUSH) && !pend_v_q) |=> s_axis_tready_o)

endmodule

`default_nettype wire
